// ===== src/pits_pkg.sv =====
// Shared types and constants of the point-in-tetrahedron search unit.
// Used by the configuration block, the controller, the datapath and the top level.
package pits_pkg;

    localparam int COORD_BITS_DEF   = 20;
    localparam int MAX_ELEMENTS_DEF = 65536;

    localparam int CNT_W      = 16;
    localparam int THR_W      = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [APB_ADDR_W-3:0] REG_DET_THRESHOLD = '0;
    localparam logic [THR_W-1:0]      DET_THRESHOLD_RST = 32'd1;

    localparam logic       KIND_QUERY  = 1'b0;
    localparam logic       KIND_VERTEX = 1'b1;
    localparam logic [1:0] LAST_SLOT   = 2'd3;

    // Vector registers of the datapath.
    localparam logic [1:0] VEC_E1 = 2'd0;
    localparam logic [1:0] VEC_E2 = 2'd1;
    localparam logic [1:0] VEC_E3 = 2'd2;
    localparam logic [1:0] VEC_P  = 2'd3;

    // Cross product groups.
    localparam logic [1:0] GRP_C23 = 2'd0;
    localparam logic [1:0] GRP_C31 = 2'd1;
    localparam logic [1:0] GRP_C12 = 2'd2;

    // Triple product accumulators.
    localparam logic [1:0] TGT_DET = 2'd0;
    localparam logic [1:0] TGT_NU  = 2'd1;
    localparam logic [1:0] TGT_NV  = 2'd2;
    localparam logic [1:0] TGT_NW  = 2'd3;

    localparam logic [1:0] LAST_COMP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGES,
        ST_RUN,
        ST_GAP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       load_query;
        logic       load_vertex;
        logic       load_edges;
        logic       issue;
        logic       dot_phase;
        logic [1:0] grp;
        logic [1:0] comp;
        logic       half;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

    function automatic logic [1:0] comp_plus1(input logic [1:0] k);
        logic [1:0] r;
        case (k)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/pits_cfg.sv =====
// Configuration register block with its APB-style port.
// Holds the determinant threshold; depends on pits_pkg.
module pits_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pits_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pits_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pits_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [pits_pkg::THR_W-1:0]      det_threshold
);
    import pits_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             thr_sel;

    assign thr_sel = (paddr[APB_ADDR_W-1:2] == REG_DET_THRESHOLD);
    assign pready  = 1'b1;
    assign prdata  = thr_sel ? APB_DATA_W'(thr_reg) : '0;
    assign det_threshold = thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= DET_THRESHOLD_RST;
        end
        else if (psel && penable && pwrite && pready && thr_sel)
        begin
            thr_reg <= THR_W'(pwdata);
        end
    end

endmodule

// ===== src/pits_ctrl.sv =====
// Sequencing controller of the point-in-tetrahedron search unit.
// Steps the shared multiplier through the cross and triple products; depends on pits_pkg.
module pits_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [1:0]          vertex_slot,
    input  pits_pkg::sts_t      sts,
    output pits_pkg::cmd_t      cmd
);
    import pits_pkg::*;

    state_t     state_reg, state_next;
    logic       dot_reg;
    logic [1:0] grp_reg;
    logic [1:0] comp_reg;
    logic       half_reg;
    logic       last_op;
    logic       accept;

    assign accept  = in_valid && in_ready;
    assign last_op = half_reg && (comp_reg == LAST_COMP)
                     && (grp_reg == (dot_reg ? TGT_NW : GRP_C12));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (kind == KIND_VERTEX) && (vertex_slot == LAST_SLOT))
                begin
                    state_next = ST_EDGES;
                end
            end
            ST_EDGES:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (last_op)
                begin
                    state_next = dot_reg ? ST_DRAIN : ST_GAP;
                end
            end
            ST_GAP:
            begin
                state_next = ST_RUN;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        cmd.load_query  = 1'b0;
        cmd.load_vertex = 1'b0;
        cmd.load_edges  = 1'b0;
        cmd.issue       = 1'b0;
        cmd.finish      = 1'b0;
        cmd.dot_phase   = dot_reg;
        cmd.grp         = grp_reg;
        cmd.comp        = comp_reg;
        cmd.half        = half_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_query  = accept && (kind == KIND_QUERY);
                cmd.load_vertex = accept && (kind == KIND_VERTEX);
            end
            ST_EDGES:
            begin
                cmd.load_edges = 1'b1;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !sts.out_busy;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dot_reg   <= 1'b0;
            grp_reg   <= '0;
            comp_reg  <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EDGES)
            begin
                dot_reg  <= 1'b0;
                grp_reg  <= '0;
                comp_reg <= '0;
                half_reg <= 1'b0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (last_op)
                begin
                    dot_reg  <= 1'b1;
                    grp_reg  <= '0;
                    comp_reg <= '0;
                    half_reg <= 1'b0;
                end
                else
                begin
                    half_reg <= !half_reg;
                    if (half_reg)
                    begin
                        if (comp_reg == LAST_COMP)
                        begin
                            comp_reg <= '0;
                            grp_reg  <= grp_reg + 2'd1;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== src/pits_dp.sv =====
// Datapath of the point-in-tetrahedron search unit: stores, shared multiplier,
// accumulators, sign decision and result register; depends on pits_pkg.
module pits_dp #(
    parameter int COORD_BITS   = pits_pkg::COORD_BITS_DEF,
    parameter int MAX_ELEMENTS = pits_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pits_pkg::cmd_t                cmd,
    output pits_pkg::sts_t                sts,
    input  logic [1:0]                    vertex_slot,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    input  logic signed [COORD_BITS-1:0]  coord_z,
    input  logic [pits_pkg::THR_W-1:0]    det_threshold,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pits_pkg::CNT_W-1:0]    element_index,
    output logic                          inside_res,
    output logic                          degenerate,
    output logic                          first_match_res
);
    import pits_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int EW    = CW + 1;
    localparam int BW    = CW + 2;
    localparam int PW    = 2 * CW + 3;
    localparam int AW    = 3 * CW + 6;
    localparam int CMPW  = (AW > THR_W + 2) ? AW : THR_W + 2;
    localparam int SAT_I = (MAX_ELEMENTS - 1 < (1 << CNT_W) - 1)
                           ? MAX_ELEMENTS - 1 : (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(SAT_I);

    logic signed [CW-1:0]   coord     [3];
    logic signed [CW-1:0]   qpt_reg   [3];
    logic signed [CW-1:0]   vtx_reg   [4][3];
    logic signed [EW-1:0]   vec_reg   [4][3];
    logic signed [PW-1:0]   crs_reg   [3][3];
    logic signed [AW-1:0]   acc_reg   [4];
    logic signed [AW-1:0]   tsum_reg;
    logic signed [PW-1:0]   prod_reg;
    logic                   pv_reg;
    logic                   pdot_reg;
    logic [1:0]             pgrp_reg;
    logic [1:0]             pcomp_reg;
    logic                   phalf_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   match_reg;
    logic                   out_valid_reg;
    logic [CNT_W-1:0]       index_reg;
    logic                   inside_reg;
    logic                   degen_reg;
    logic                   first_reg;

    logic [1:0]             k1;
    logic [1:0]             k2;
    logic [1:0]             va;
    logic [1:0]             vb;
    logic [1:0]             cg;
    logic signed [EW-1:0]   mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [PW-1:0]   mul_p;
    logic signed [AW-1:0]   px;
    logic signed [AW-1:0]   addend;
    logic signed [AW-1:0]   det;
    logic signed [CMPW-1:0] det_ext;
    logic signed [CMPW-1:0] thr_ext;
    logic                   det_neg;
    logic                   det_zero;
    logic                   degen;
    logic                   hit;

    assign coord[0] = coord_x;
    assign coord[1] = coord_y;
    assign coord[2] = coord_z;

    assign k1 = comp_plus1(cmd.comp);
    assign k2 = comp_plus1(k1);

    always_comb
    begin
        va = VEC_E1;
        vb = VEC_E2;
        cg = GRP_C23;
        if (cmd.dot_phase)
        begin
            unique case (cmd.grp)
                TGT_DET: begin va = VEC_E1; cg = GRP_C23; end
                TGT_NU:  begin va = VEC_P;  cg = GRP_C23; end
                TGT_NV:  begin va = VEC_P;  cg = GRP_C31; end
                default: begin va = VEC_P;  cg = GRP_C12; end
            endcase
            mul_a = vec_reg[va][cmd.comp];
            mul_b = cmd.half ? crs_reg[cg][cmd.comp][PW-1:EW]
                             : $signed({1'b0, crs_reg[cg][cmd.comp][EW-1:0]});
        end
        else
        begin
            unique case (cmd.grp)
                GRP_C23: begin va = VEC_E2; vb = VEC_E3; end
                GRP_C31: begin va = VEC_E3; vb = VEC_E1; end
                default: begin va = VEC_E1; vb = VEC_E2; end
            endcase
            mul_a = cmd.half ? vec_reg[va][k2] : vec_reg[va][k1];
            mul_b = cmd.half ? BW'(vec_reg[vb][k1]) : BW'(vec_reg[vb][k2]);
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign px     = AW'(prod_reg);
    assign addend = phalf_reg ? (px <<< EW) : px;

    assign det      = acc_reg[TGT_DET];
    assign det_neg  = det[AW-1];
    assign det_zero = (det == '0);
    assign det_ext  = CMPW'(det);
    assign thr_ext  = CMPW'($signed({1'b0, det_threshold}));
    assign degen    = det_neg ? (det_ext > -thr_ext) : (det_ext < thr_ext);
    assign hit      = !degen && !det_zero
                      && ((acc_reg[TGT_NU] == '0) || (acc_reg[TGT_NU][AW-1] == det_neg))
                      && ((acc_reg[TGT_NV] == '0) || (acc_reg[TGT_NV][AW-1] == det_neg))
                      && ((acc_reg[TGT_NW] == '0) || (acc_reg[TGT_NW][AW-1] == det_neg))
                      && ((tsum_reg == '0) || (tsum_reg[AW-1] == det_neg));

    assign sts.out_busy   = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign element_index  = index_reg;
    assign inside_res     = inside_reg;
    assign degenerate     = degen_reg;
    assign first_match_res = first_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_vertex)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vtx_reg[vertex_slot][k] <= coord[k];
            end
        end
        if (cmd.load_edges)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vec_reg[VEC_E1][k] <= EW'(vtx_reg[1][k]) - EW'(vtx_reg[0][k]);
                vec_reg[VEC_E2][k] <= EW'(vtx_reg[2][k]) - EW'(vtx_reg[0][k]);
                vec_reg[VEC_E3][k] <= EW'(vtx_reg[3][k]) - EW'(vtx_reg[0][k]);
                vec_reg[VEC_P][k]  <= EW'(qpt_reg[k]) - EW'(vtx_reg[0][k]);
            end
            for (int t = 0; t < 4; t++)
            begin
                acc_reg[t] <= '0;
            end
            tsum_reg <= '0;
        end
        else if (pv_reg && pdot_reg)
        begin
            acc_reg[pgrp_reg] <= acc_reg[pgrp_reg] + addend;
            tsum_reg <= (pgrp_reg == TGT_DET) ? tsum_reg + addend : tsum_reg - addend;
        end
        if (pv_reg && !pdot_reg)
        begin
            crs_reg[pgrp_reg][pcomp_reg] <= phalf_reg
                ? crs_reg[pgrp_reg][pcomp_reg] - prod_reg : prod_reg;
        end
        prod_reg  <= mul_p;
        pdot_reg  <= cmd.dot_phase;
        pgrp_reg  <= cmd.grp;
        pcomp_reg <= cmd.comp;
        phalf_reg <= cmd.half;
        if (cmd.finish)
        begin
            index_reg  <= count_reg;
            inside_reg <= hit;
            degen_reg  <= degen;
            first_reg  <= hit && !match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                qpt_reg[k] <= '0;
            end
            pv_reg        <= 1'b0;
            count_reg     <= '0;
            match_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.issue;
            if (cmd.load_query)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    qpt_reg[k] <= coord[k];
                end
                count_reg <= '0;
                match_reg <= 1'b0;
            end
            else if (cmd.finish)
            begin
                match_reg <= match_reg || hit;
                if (count_reg < CNT_SAT)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/point_in_tetrahedron_search_unit.sv =====
// Point-in-tetrahedron search unit: top level joining configuration, controller and datapath.
// Beats are taken only while idle; query and vertex beats for corners 0 to 2 give no result.
// A corner 3 beat starts a search: an edge state, the slots of the single shared multiplier
// for three cross products, a gap state, its slots for four triple products (all in split
// halves), a drain state, and a decision state that holds while an earlier result is not taken.
// Reset is asynchronous and active low; it clears query, count, flag, control.
module point_in_tetrahedron_search_unit #(
    parameter int COORD_BITS   = pits_pkg::COORD_BITS_DEF,
    parameter int MAX_ELEMENTS = pits_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pits_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pits_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pits_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [1:0]                      vertex_slot,
    input  logic signed [COORD_BITS-1:0]    coord_x,
    input  logic signed [COORD_BITS-1:0]    coord_y,
    input  logic signed [COORD_BITS-1:0]    coord_z,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pits_pkg::CNT_W-1:0]      element_index,
    output logic                            inside_res,
    output logic                            degenerate,
    output logic                            first_match_res
);
    import pits_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [THR_W-1:0] det_threshold;

    pits_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .det_threshold (det_threshold)
    );

    pits_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .vertex_slot (vertex_slot),
        .sts         (sts),
        .cmd         (cmd)
    );

    pits_dp #(
        .COORD_BITS   (COORD_BITS),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .vertex_slot     (vertex_slot),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .det_threshold   (det_threshold),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .element_index   (element_index),
        .inside_res      (inside_res),
        .degenerate      (degenerate),
        .first_match_res (first_match_res)
    );

endmodule
